// File: hw/rtl/sorted_array_priority_queue_unit_defines.svh
// Assertion macros for the sorted array priority queue.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SPQ_ASSERT_SAME(lbl, ante, cons, msg)
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/spq_pkg.sv
package spq_pkg;

  // Capacity of the queue.
  localparam int DEPTH   = 8;
  localparam int FILL_W  = $clog2(DEPTH + 1);
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 4;

  // Request action codes.
  localparam logic [1:0] ACT_INSERT  = 2'd0;
  localparam logic [1:0] ACT_DELETE  = 2'd1;
  localparam logic [1:0] ACT_DISPLAY = 2'd2;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } spq_status_t;

  // Operation broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } spq_op_t;

  typedef enum logic {
    S_IDLE    = 1'b0,
    S_DISPLAY = 1'b1
  } spq_state_t;

  typedef struct packed {
    logic [1:0]               action;
    logic signed [DATA_W-1:0] value;
  } spq_req_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] entry;
    logic [COUNT_W-1:0]       count;
    logic                     last;
  } spq_rsp_t;

  // Command shared by all cells.
  typedef struct packed {
    spq_op_t                  op;
    logic signed [DATA_W-1:0] value;
  } spq_cmd_t;

  // Per-cell position flags derived from the fill count.
  typedef struct packed {
    logic occupied;  // cell holds a live entry
    logic tail;      // cell holds the last live entry
  } spq_pos_t;

endpackage

// File: hw/rtl/sorted_array_priority_queue_unit.sv
// Channel   Handshake          Payload                     Direction
// request   start / busy       in_req  (action, value)      in
// result    out_valid strobe   out_rsp (status, entry,      out
//                              count, last)
//
// For insert, delete and unused actions the row of cells updates at the
// accepting edge and the result strobes in the next cycle. A display of
// stored entries keeps busy high while the row rotates by one cell per
// cycle and the head cell feeds each result. A display of an empty queue
// answers with a single result. Reset (rst_n low, synchronous) empties the
// queue and drops any display. Results cannot be held off.
module sorted_array_priority_queue_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  spq_pkg::spq_req_t in_req,
  output logic              out_valid,
  output spq_pkg::spq_rsp_t out_rsp
);

`include "sorted_array_priority_queue_unit_defines.svh"

  localparam int DEPTH  = spq_pkg::DEPTH;
  localparam int FILL_W = spq_pkg::FILL_W;
  localparam int DATA_W = spq_pkg::DATA_W;

  // Control state.
  spq_pkg::spq_state_t state_r, state_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic [FILL_W-1:0]   disp_idx_r, disp_idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  spq_pkg::spq_rsp_t   out_rsp_r, out_rsp_nxt;

  // Chain wiring.
  spq_pkg::spq_cmd_t          cmd;
  spq_pkg::spq_pos_t          pos   [DEPTH];
  logic signed [DATA_W-1:0]   cdata [DEPTH];
  logic                       cge   [DEPTH];
  logic                       chit  [DEPTH];

  logic accept;
  logic full;
  logic found;
  logic disp_last;

  assign accept    = start && !busy;
  assign full      = (fill_r == FILL_W'(DEPTH));
  // The match flag ripples down the row; the last cell sees whether any
  // live entry equals the request value.
  assign found     = chit[DEPTH-1];
  assign disp_last = ((disp_idx_r + FILL_W'(1)) == fill_r);

  assign busy      = (state_r == spq_pkg::S_DISPLAY);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // The row of cells. Each cell sees its two neighbors and the head cell,
  // which closes the ring at the tail during a display.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_d;
    logic signed [DATA_W-1:0] right_d;
    logic                     left_g;
    logic                     hit_i;

    assign pos[i].occupied = (FILL_W'(i) < fill_r);
    assign pos[i].tail     = (FILL_W'(i + 1) == fill_r);

    if (i == 0) begin : g_head
      assign left_d = '0;
      assign left_g = 1'b0;
      assign hit_i  = 1'b0;
    end else begin : g_body
      assign left_d = cdata[i-1];
      assign left_g = cge[i-1];
      assign hit_i  = chit[i-1];
    end

    // The slot past the tail is never live, so whatever it shifts in is
    // beyond the fill count and never read.
    if (i == DEPTH - 1) begin : g_tail
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cdata[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .pos        (pos[i]),
      .left_data  (left_d),
      .left_ge    (left_g),
      .right_data (right_d),
      .head_data  (cdata[0]),
      .hit_in     (hit_i),
      .data       (cdata[i]),
      .ge_out     (cge[i]),
      .hit_out    (chit[i])
    );
  end

  // Next state, cell command and the result of the request.
  always_comb begin
    state_nxt         = state_r;
    fill_nxt          = fill_r;
    disp_idx_nxt      = disp_idx_r;
    out_valid_nxt     = 1'b0;
    out_rsp_nxt       = out_rsp_r;
    cmd.op            = spq_pkg::OP_HOLD;
    cmd.value         = in_req.value;

    case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          // Most requests answer with one result echoing the value.
          out_valid_nxt       = 1'b1;
          out_rsp_nxt.status  = spq_pkg::STAT_OK;
          out_rsp_nxt.entry   = in_req.value;
          out_rsp_nxt.count   = spq_pkg::COUNT_W'(fill_r);
          out_rsp_nxt.last    = 1'b1;
          case (in_req.action)
            spq_pkg::ACT_INSERT: begin
              if (full) begin
                out_rsp_nxt.status = spq_pkg::STAT_FULL;
              end else begin
                cmd.op            = spq_pkg::OP_INSERT;
                fill_nxt          = fill_r + FILL_W'(1);
                out_rsp_nxt.count = spq_pkg::COUNT_W'(fill_r + FILL_W'(1));
              end
            end
            spq_pkg::ACT_DELETE: begin
              if (fill_r == '0) begin
                out_rsp_nxt.status = spq_pkg::STAT_EMPTY;
              end else if (!found) begin
                out_rsp_nxt.status = spq_pkg::STAT_NOT_FOUND;
              end else begin
                cmd.op            = spq_pkg::OP_DELETE;
                fill_nxt          = fill_r - FILL_W'(1);
                out_rsp_nxt.count = spq_pkg::COUNT_W'(fill_r - FILL_W'(1));
              end
            end
            spq_pkg::ACT_DISPLAY: begin
              if (fill_r == '0) begin
                out_rsp_nxt.status = spq_pkg::STAT_EMPTY;
                out_rsp_nxt.entry  = '0;
              end else begin
                // Stream the entries from the display state.
                out_valid_nxt = 1'b0;
                disp_idx_nxt  = '0;
                state_nxt     = spq_pkg::S_DISPLAY;
              end
            end
            default: begin
              // An unused action leaves the queue untouched.
            end
          endcase
        end
      end
      spq_pkg::S_DISPLAY: begin
        // The head cell always holds the next entry to report; rotating
        // the live part of the row by one brings up the following one.
        // After fill_r rotations the row is back in its original order.
        cmd.op             = spq_pkg::OP_ROTATE;
        out_valid_nxt      = 1'b1;
        out_rsp_nxt.status = spq_pkg::STAT_OK;
        out_rsp_nxt.entry  = cdata[0];
        out_rsp_nxt.count  = spq_pkg::COUNT_W'(fill_r);
        out_rsp_nxt.last   = disp_last;
        disp_idx_nxt       = disp_idx_r + FILL_W'(1);
        if (disp_last) begin
          state_nxt = spq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      fill_r      <= '0;
      disp_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      disp_idx_r  <= disp_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  // The fill count never passes the capacity.
  `SPQ_ASSERT_SAME(a_fill_bound, 1'b1, fill_r <= FILL_W'(DEPTH), "fill count above capacity")
  // A display only runs over a non-empty queue.
  `SPQ_ASSERT_SAME(a_disp_nonempty, busy, fill_r != '0, "display running on empty queue")
  // An accepted insert into a queue with room grows it by exactly one.
  `SPQ_ASSERT_NEXT(a_insert_grows, accept && (in_req.action == spq_pkg::ACT_INSERT) && !full, fill_r == $past(fill_r) + FILL_W'(1), "insert did not grow the queue")
  // A result that is not the last one of its request is followed by another.
  `SPQ_ASSERT_NEXT(a_stream_continues, out_valid && !out_rsp.last, out_valid, "result stream broken")

endmodule

// File: hw/rtl/spq_cell.sv
module spq_cell (
  input  logic                               clk,
  input  spq_pkg::spq_cmd_t                  cmd,
  input  spq_pkg::spq_pos_t                  pos,
  input  logic signed [spq_pkg::DATA_W-1:0]  left_data,
  input  logic                               left_ge,
  input  logic signed [spq_pkg::DATA_W-1:0]  right_data,
  input  logic signed [spq_pkg::DATA_W-1:0]  head_data,
  input  logic                               hit_in,
  output logic signed [spq_pkg::DATA_W-1:0]  data,
  output logic                               ge_out,
  output logic                               hit_out
);

  logic signed [spq_pkg::DATA_W-1:0] data_r;
  logic signed [spq_pkg::DATA_W-1:0] data_nxt;

  // A free slot always accepts; a live slot accepts when the new value is
  // not smaller. Because the row is sorted, this flag only rises along it.
  assign ge_out  = !pos.occupied || (cmd.value >= data_r);
  // Set from the first live cell that matches the value and onward.
  assign hit_out = hit_in || (pos.occupied && (data_r == cmd.value));
  assign data    = data_r;

  always_comb begin
    case (cmd.op)
      spq_pkg::OP_INSERT: begin
        if (left_ge) begin
          data_nxt = left_data;
        end else if (ge_out) begin
          data_nxt = cmd.value;
        end else begin
          data_nxt = data_r;
        end
      end
      spq_pkg::OP_DELETE: begin
        data_nxt = hit_out ? right_data : data_r;
      end
      spq_pkg::OP_ROTATE: begin
        data_nxt = pos.tail ? head_data : right_data;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: verif/tb_sorted_array_priority_queue_unit.sv
`timescale 1ns / 100ps

module tb_sorted_array_priority_queue_unit;

  // Action code 3 has no name in the package. The block treats it as a no-op.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // Slowest legal run: about 270 requests, each with up to 8 results plus an
  // 81 percent sender gap. That stays far below this cycle count.
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned RANDOM_REQUESTS = 252;
  localparam int unsigned PHASES          = 4;
  localparam int unsigned POOL_SIZE       = 6;
  localparam int unsigned MAX_REPORTS     = 10;

  // A request waiting for the driver, together with the chance (in percent)
  // that the driver idles instead of presenting it whenever the slot is free.
  typedef struct {
    spq_pkg::spq_req_t req;
    int unsigned       idle_pct;
  } queued_req_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  spq_pkg::spq_req_t in_req;
  logic              out_valid;
  spq_pkg::spq_rsp_t out_rsp;

  queued_req_t       pending_reqs[$];
  spq_pkg::spq_rsp_t expected_rsps[$];

  // The predicted contents of the queue, largest value first.
  logic signed [spq_pkg::DATA_W-1:0] sorted_vals[spq_pkg::DEPTH];
  int unsigned                       sorted_fill = 0;

  int unsigned                       mismatch_count = 0;
  int unsigned                       cycle_count = 0;
  int unsigned                       phase_idle_pct;
  logic signed [spq_pkg::DATA_W-1:0] value_pool[POOL_SIZE];

  sorted_array_priority_queue_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic spq_pkg::spq_rsp_t make_rsp(spq_pkg::spq_status_t st,
                                                 logic signed [spq_pkg::DATA_W-1:0] entry,
                                                 int unsigned cnt, logic last);
    spq_pkg::spq_rsp_t r;
    r.status = st;
    r.entry  = entry;
    r.count  = spq_pkg::COUNT_W'(cnt);
    r.last   = last;
    return r;
  endfunction

  // Apply one accepted request to the predicted contents and queue every
  // result that the request should produce, in the order they will appear.
  function automatic void predict_request(spq_pkg::spq_req_t req);
    logic signed [spq_pkg::DATA_W-1:0] v;
    int unsigned                       pos;
    int unsigned                       j;
    v = req.value;
    case (req.action)
      spq_pkg::ACT_INSERT: begin
        if (sorted_fill >= spq_pkg::DEPTH) begin
          expected_rsps.push_back(make_rsp(spq_pkg::STAT_FULL, v, sorted_fill, 1'b1));
        end else begin
          // The new value goes ahead of the first entry that is not larger.
          pos = 0;
          while (pos < sorted_fill && v < sorted_vals[pos]) pos++;
          for (j = sorted_fill; j > pos; j--) sorted_vals[j] = sorted_vals[j - 1];
          sorted_vals[pos] = v;
          sorted_fill++;
          expected_rsps.push_back(make_rsp(spq_pkg::STAT_OK, v, sorted_fill, 1'b1));
        end
      end
      spq_pkg::ACT_DELETE: begin
        if (sorted_fill == 0) begin
          expected_rsps.push_back(make_rsp(spq_pkg::STAT_EMPTY, v, 0, 1'b1));
        end else begin
          pos = 0;
          while (pos < sorted_fill && sorted_vals[pos] != v) pos++;
          if (pos == sorted_fill) begin
            expected_rsps.push_back(make_rsp(spq_pkg::STAT_NOT_FOUND, v, sorted_fill,
                                             1'b1));
          end else begin
            for (j = pos; j + 1 < sorted_fill; j++) sorted_vals[j] = sorted_vals[j + 1];
            sorted_fill--;
            expected_rsps.push_back(make_rsp(spq_pkg::STAT_OK, v, sorted_fill, 1'b1));
          end
        end
      end
      spq_pkg::ACT_DISPLAY: begin
        if (sorted_fill == 0) begin
          expected_rsps.push_back(make_rsp(spq_pkg::STAT_EMPTY, '0, 0, 1'b1));
        end else begin
          for (j = 0; j < sorted_fill; j++) begin
            expected_rsps.push_back(make_rsp(spq_pkg::STAT_OK, sorted_vals[j], sorted_fill,
                                             j + 1 == sorted_fill));
          end
        end
      end
      default: begin
        expected_rsps.push_back(make_rsp(spq_pkg::STAT_OK, v, sorted_fill, 1'b1));
      end
    endcase
  endfunction

  function automatic void report_mismatch(string what, spq_pkg::spq_rsp_t want,
                                          spq_pkg::spq_rsp_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected status %0d entry %0d count %0d last %0d,",
               $realtime, what, want.status, want.entry, want.count, want.last);
      $display("    got status %0d entry %0d count %0d last %0d",
               got.status, got.entry, got.count, got.last);
    end
  endfunction

  function automatic void queue_request(logic [1:0] action,
                                        logic signed [spq_pkg::DATA_W-1:0] value);
    queued_req_t q;
    q.req.action = action;
    q.req.value  = value;
    q.idle_pct   = phase_idle_pct;
    pending_reqs.push_back(q);
  endfunction

  // The pool holds a few values that repeat for a while, so that deletes
  // find stored entries and inserts meet equal values already in the queue.
  function automatic void refresh_value_pool();
    int unsigned k;
    for (k = 0; k < POOL_SIZE; k++) begin
      case ($urandom_range(3))
        0: value_pool[k] = $urandom();
        1: value_pool[k] = int'($urandom_range(8)) - 4;
        2: value_pool[k] = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        default: value_pool[k] = $urandom_range(1) ? -1 : 0;
      endcase
    end
  endfunction

  function automatic void queue_random_request(int unsigned insert_pct);
    int unsigned                       roll;
    logic signed [spq_pkg::DATA_W-1:0] v;
    roll = $urandom_range(99);
    if ($urandom_range(99) < 75) begin
      v = value_pool[$urandom_range(POOL_SIZE - 1)];
    end else begin
      v = $urandom();
    end
    if (roll < 4) begin
      queue_request(ACT_UNUSED, v);
    end else if (roll < 16) begin
      queue_request(spq_pkg::ACT_DISPLAY, v);
    end else if (roll < 16 + insert_pct * 84 / 100) begin
      queue_request(spq_pkg::ACT_INSERT, v);
    end else begin
      queue_request(spq_pkg::ACT_DELETE, v);
    end
  endfunction

  // Driver. A request stays on in_req with start high until the block takes
  // it at an edge where busy is low. Once the slot is free, the driver either
  // presents the next request or idles, as the request's phase asks.
  always @(posedge clk) begin
    if (!rst_n) begin
      start  <= 1'b0;
      in_req <= '0;
    end else if (!start || !busy) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= pending_reqs[0].idle_pct) begin
        in_req <= pending_reqs[0].req;
        start  <= 1'b1;
        void'(pending_reqs.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. All signals are sampled at the rising edge, before any update
  // of that edge takes effect. A result strobe is compared with the oldest
  // expectation first. After that, a request accepted at this same edge
  // extends the list. Results of one request never share its acceptance
  // edge, so this order keeps them in sequence.
  always @(posedge clk) begin
    spq_pkg::spq_rsp_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("result with nothing pending", '0, out_rsp);
        end else begin
          want = expected_rsps.pop_front();
          if (out_rsp.status !== want.status || out_rsp.entry !== want.entry ||
              out_rsp.count !== want.count || out_rsp.last !== want.last) begin
            report_mismatch("result mismatch", want, out_rsp);
          end
        end
      end
      if (start && !busy) begin
        predict_request(in_req);
      end
    end
  end

  // Watchdog for a block that hangs or never drains.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_sorted_array_priority_queue_unit: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned p;
    int unsigned n;
    int unsigned insert_pct;
    rst_n      = 1'b0;
    insert_pct = 50;

    // The directed requests come first and are sent back to back. They
    // cover both empty cases, the extreme values, equal values, filling the
    // queue and inserting into a full one, a display of a full queue, a
    // delete of a missing value, deletes at the head, at the tail and of a
    // duplicate, and the unused action code.
    phase_idle_pct = 0;
    queue_request(spq_pkg::ACT_DISPLAY, 32'sh1234_5678);
    queue_request(spq_pkg::ACT_DELETE, 32'sh0000_0007);
    queue_request(spq_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
    queue_request(spq_pkg::ACT_INSERT, 32'sh8000_0000);
    queue_request(spq_pkg::ACT_INSERT, 0);
    queue_request(spq_pkg::ACT_INSERT, -1);
    queue_request(spq_pkg::ACT_INSERT, 5);
    queue_request(spq_pkg::ACT_INSERT, 5);
    queue_request(spq_pkg::ACT_INSERT, 32'sh5555_5555);
    queue_request(spq_pkg::ACT_INSERT, 32'shAAAA_AAAA);
    queue_request(spq_pkg::ACT_INSERT, 3);
    queue_request(spq_pkg::ACT_DISPLAY, -1);
    queue_request(spq_pkg::ACT_DELETE, 1234);
    queue_request(spq_pkg::ACT_DELETE, 32'sh8000_0000);
    queue_request(spq_pkg::ACT_DELETE, 32'sh7FFF_FFFF);
    queue_request(spq_pkg::ACT_DELETE, 5);
    queue_request(ACT_UNUSED, -1);
    queue_request(spq_pkg::ACT_DISPLAY, 0);

    // The random part runs in four phases: no idling, a sender idle most of
    // the time, a second phase with no idling (the receiver cannot stall),
    // and a sender idle a quarter of the time. In blocks of sixteen requests
    // the mix leans toward inserts or toward deletes, so the queue both
    // fills up and drains.
    for (p = 0; p < PHASES; p++) begin
      phase_idle_pct = (p == 1) ? 81 : (p == 3) ? 25 : 0;
      for (n = 0; n < RANDOM_REQUESTS / PHASES; n++) begin
        if (n % 16 == 0) begin
          refresh_value_pool();
          insert_pct = $urandom_range(1) ? 75 : 30;
        end
        queue_random_request(insert_pct);
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() > 0 || start) @(posedge clk);
    while (expected_rsps.size() > 0) @(posedge clk);
    // Extra cycles to catch any stray result that follows the last one.
    repeat (spq_pkg::DEPTH + 4) @(posedge clk);

    if (mismatch_count == 0 && expected_rsps.size() == 0) begin
      $display("tb_sorted_array_priority_queue_unit: done, clean");
    end else begin
      $display("tb_sorted_array_priority_queue_unit: done, errors");
    end
    $finish;
  end

endmodule
